/* rtl/ctt_pkg.sv */
// Shared types and constants for the countdown timer table.
// Used by every module of the block; depends on nothing.
`default_nettype none

package ctt_pkg;

  localparam int NUM_TIMERS = 16;
  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W = $clog2(NUM_TIMERS + 1);
  localparam int ID_W = 16;
  localparam int TICK_W = 16;

  // Both queues must have a power-of-two depth so the pointers wrap by themselves.
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);
  localparam int RESQ_DEPTH = 2;
  localparam int RESQ_PTR_W = (RESQ_DEPTH > 1) ? $clog2(RESQ_DEPTH) : 1;
  localparam int RESQ_CNT_W = $clog2(RESQ_DEPTH + 1);

  localparam logic [1:0] REQ_SET = 2'd0;
  localparam logic [1:0] REQ_KILL = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;

  typedef enum logic [1:0] {
    OP_SET   = 2'd0,
    OP_KILL  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_TICK  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_RELOADED  = 3'd0,
    ST_ADDED     = 3'd1,
    ST_FULL      = 3'd2,
    ST_KILLED    = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_CLEARED   = 3'd5,
    ST_EXPIRED   = 3'd6,
    ST_TICK_NONE = 3'd7
  } status_t;

  typedef struct packed {
    op_t              op;
    logic [ID_W-1:0]   id;
    logic [TICK_W-1:0] ticks;
  } cmd_t;

  typedef struct packed {
    status_t         status;
    logic [ID_W-1:0] expired_id;
    logic            last;
  } res_t;

endpackage

`default_nettype wire

/* rtl/ctt_front.sv */
// Front end: accepts requests, decodes them into commands and queues them.
// Depends on ctt_pkg.
`default_nettype none

module ctt_front import ctt_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  output logic                     full,
  input  wire logic [1:0]          req_type,
  input  wire logic [ID_W-1:0]     timer_id,
  input  wire logic [TICK_W-1:0]   ticks,
  output logic                     cmd_valid,
  output cmd_t                     cmd,
  input  wire logic                cmd_take
);

  cmd_t                  qmem [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr;
  logic [CMDQ_PTR_W-1:0] rd_ptr;
  logic [CMDQ_CNT_W-1:0] qcnt;
  logic                  enq;
  logic                  deq;
  cmd_t                  dec;

  // Unused request code is consumed by the transfer but never queued.
  always_comb begin
    enq = push && !full;
    dec.id = timer_id;
    dec.ticks = ticks;
    dec.op = OP_SET;
    case (req_type)
      REQ_SET: dec.op = OP_SET;
      REQ_KILL: dec.op = (timer_id == '0) ? OP_CLEAR : OP_KILL;
      REQ_TICK: dec.op = OP_TICK;
      default: enq = 1'b0;
    endcase
  end

  assign full = (qcnt == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign cmd_valid = (qcnt != '0);
  assign cmd = qmem[rd_ptr];
  assign deq = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      qcnt <= '0;
    end else begin
      if (enq) begin
        qmem[wr_ptr] <= dec;
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (deq) rd_ptr <= rd_ptr + 1'b1;
      if (enq && !deq) qcnt <= qcnt + 1'b1;
      else if (deq && !enq) qcnt <= qcnt - 1'b1;
    end
  end

endmodule

`default_nettype wire

/* rtl/ctt_engine.sv */
// Back end: holds the timer table and runs one command at a time,
// one table entry per cycle while the result queue has room. Depends on ctt_pkg.
`default_nettype none

module ctt_engine import ctt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  input  wire cmd_t cmd,
  output logic      cmd_take,
  output logic      res_push,
  output res_t      res,
  input  wire logic res_ready
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  state_t            state;
  logic [ID_W-1:0]   ids [NUM_TIMERS];
  logic [TICK_W-1:0] rem [NUM_TIMERS];
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  pos;
  logic [CNT_W-1:0]  pos_m1;
  cmd_t              cur;
  logic              pend_valid;
  logic [ID_W-1:0]   pend_id;

  logic [IDX_W-1:0]  cur_idx;
  logic [ID_W-1:0]   rd_id;
  logic [TICK_W-1:0] rd_rem;
  logic              scan_end;
  logic              hit;
  logic              expire;
  logic              step;
  logic              done;
  logic              advance;
  logic              rm_en;
  logic              dec_en;
  logic              reload_en;
  logic              app_en;
  logic              clr;
  logic              pend_load;

  // Set and kill scan upward from entry 0; a tick walks down from the top.
  assign pos_m1 = pos - 1'b1;
  assign cur_idx = (cur.op == OP_TICK) ? pos_m1[IDX_W-1:0] : pos[IDX_W-1:0];
  assign rd_id = ids[cur_idx];
  assign rd_rem = rem[cur_idx];
  assign scan_end = (cur.op == OP_TICK) ? (pos == '0) : (pos == count);
  assign hit = (rd_id == cur.id);
  assign expire = (rd_rem <= TICK_W'(1));
  assign step = (state == S_RUN) && res_ready;
  assign cmd_take = (state == S_IDLE) && cmd_valid;

  always_comb begin
    res_push = 1'b0;
    res.status = ST_RELOADED;
    res.expired_id = '0;
    res.last = 1'b1;
    done = 1'b0;
    advance = 1'b0;
    rm_en = 1'b0;
    dec_en = 1'b0;
    reload_en = 1'b0;
    app_en = 1'b0;
    clr = 1'b0;
    pend_load = 1'b0;
    if (step) begin
      case (cur.op)
        OP_SET: begin
          if (scan_end) begin
            res_push = 1'b1;
            done = 1'b1;
            if (count < CNT_W'(NUM_TIMERS)) begin
              app_en = 1'b1;
              res.status = ST_ADDED;
            end else begin
              res.status = ST_FULL;
            end
          end else if (hit) begin
            reload_en = 1'b1;
            res_push = 1'b1;
            res.status = ST_RELOADED;
            done = 1'b1;
          end else begin
            advance = 1'b1;
          end
        end
        OP_KILL: begin
          if (scan_end) begin
            res_push = 1'b1;
            res.status = ST_NOT_FOUND;
            done = 1'b1;
          end else if (hit) begin
            rm_en = 1'b1;
            res_push = 1'b1;
            res.status = ST_KILLED;
            done = 1'b1;
          end else begin
            advance = 1'b1;
          end
        end
        OP_CLEAR: begin
          clr = 1'b1;
          res_push = 1'b1;
          res.status = ST_CLEARED;
          done = 1'b1;
        end
        OP_TICK: begin
          // An expiry is held back until the next one is found or the walk ends, so the final one can carry last.
          if (scan_end) begin
            res_push = 1'b1;
            done = 1'b1;
            res.status = pend_valid ? ST_EXPIRED : ST_TICK_NONE;
            res.expired_id = pend_valid ? pend_id : '0;
          end else begin
            advance = 1'b1;
            if (expire) begin
              rm_en = 1'b1;
              pend_load = 1'b1;
              if (pend_valid) begin
                res_push = 1'b1;
                res.status = ST_EXPIRED;
                res.expired_id = pend_id;
                res.last = 1'b0;
              end
            end else begin
              dec_en = 1'b1;
            end
          end
        end
        default: done = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_take) begin
            cur <= cmd;
            pos <= (cmd.op == OP_TICK) ? count : '0;
            pend_valid <= 1'b0;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (done) state <= S_IDLE;
          if (advance) pos <= (cur.op == OP_TICK) ? pos_m1 : pos + 1'b1;
          if (pend_load) begin
            pend_valid <= 1'b1;
            pend_id <= rd_id;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (clr) count <= '0;
      else if (app_en) count <= count + 1'b1;
      else if (rm_en) count <= count - 1'b1;
    end
  end

  // Removal closes the gap: every entry above the removed one moves down.
  always_ff @(posedge clk) begin
    for (int j = 0; j < NUM_TIMERS - 1; j++) begin
      if (rm_en && (IDX_W'(j) >= cur_idx)) begin
        ids[j] <= ids[j+1];
        rem[j] <= rem[j+1];
      end
    end
    if (reload_en) rem[cur_idx] <= cur.ticks;
    if (dec_en) rem[cur_idx] <= rd_rem - 1'b1;
    if (app_en) begin
      ids[count[IDX_W-1:0]] <= cur.id;
      rem[count[IDX_W-1:0]] <= cur.ticks;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(NUM_TIMERS))
    else $error("timer count above table size");

  a_push_space: assert property (@(posedge clk) disable iff (rst)
    res_push |-> res_ready)
    else $error("result transfer into a full queue");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (res_push && res.status == ST_CLEARED) |=> (count == '0))
    else $error("table not empty after clear");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !res_push)
    else $error("result produced while idle");

  a_tick_walk: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN && cur.op == OP_TICK) |-> (pos <= count))
    else $error("tick walk position past table end");

endmodule

`default_nettype wire

/* rtl/ctt_res_fifo.sv */
// Result queue between the table engine and the result port.
// Depends on ctt_pkg.
`default_nettype none

module ctt_res_fifo import ctt_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            res_push,
  input  wire res_t            res,
  output logic                 res_ready,
  output logic                 empty,
  input  wire logic            pop,
  output logic [2:0]           status,
  output logic [ID_W-1:0]      expired_id,
  output logic                 last
);

  res_t                  qmem [RESQ_DEPTH];
  logic [RESQ_PTR_W-1:0] wr_ptr;
  logic [RESQ_PTR_W-1:0] rd_ptr;
  logic [RESQ_CNT_W-1:0] qcnt;
  logic                  enq;
  logic                  deq;
  res_t                  head;

  assign res_ready = (qcnt != RESQ_CNT_W'(RESQ_DEPTH));
  assign empty = (qcnt == '0);
  assign enq = res_push && res_ready;
  assign deq = pop && !empty;
  assign head = qmem[rd_ptr];
  assign status = head.status;
  assign expired_id = head.expired_id;
  assign last = head.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      qcnt <= '0;
    end else begin
      if (enq) begin
        qmem[wr_ptr] <= res;
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (deq) rd_ptr <= rd_ptr + 1'b1;
      if (enq && !deq) qcnt <= qcnt + 1'b1;
      else if (deq && !enq) qcnt <= qcnt - 1'b1;
    end
  end

endmodule

`default_nettype wire

/* rtl/countdown_timer_table_unit.sv */
// Top level of the countdown timer table: front end, table engine, result queue.
// Depends on ctt_pkg, ctt_front, ctt_engine and ctt_res_fifo.
`default_nettype none

// Table of up to NUM_TIMERS countdown timers, kept in insertion order. Requests
// go in through a short command queue and results come out of a short result
// queue, so either side may stall independently. The engine handles one request
// at a time and looks at one table entry per cycle while the result queue has
// room. A set or a kill is taken from the command queue, then scans upward from
// entry 0 until it finds the id or passes the last entry; a kill of id 0 instead
// empties the table. A tick walks every entry from the top down. A set or a kill
// gives one result. A tick gives one result per expired timer, highest table
// position first, or a single "none expired" result. The final result of each
// request has last set. Request code 3 is taken and dropped without a result.
// There is no clearing pass after reset.
module countdown_timer_table_unit import ctt_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  output logic                     full,
  input  wire logic [1:0]          req_type,
  input  wire logic [ID_W-1:0]     timer_id,
  input  wire logic [TICK_W-1:0]   ticks,
  output logic                     empty,
  input  wire logic                pop,
  output logic [2:0]               status,
  output logic [ID_W-1:0]          expired_id,
  output logic                     last
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_take;
  logic res_push;
  res_t res;
  logic res_ready;

  ctt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .req_type  (req_type),
    .timer_id  (timer_id),
    .ticks     (ticks),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  ctt_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .res_push  (res_push),
    .res       (res),
    .res_ready (res_ready)
  );

  ctt_res_fifo u_res_fifo (
    .clk        (clk),
    .rst        (rst),
    .res_push   (res_push),
    .res        (res),
    .res_ready  (res_ready),
    .empty      (empty),
    .pop        (pop),
    .status     (status),
    .expired_id (expired_id),
    .last       (last)
  );

endmodule

`default_nettype wire
